[src/assert_macros.svh]
// Assertion helpers shared by the FIFO, front and back RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  `ASSERT_CLK(lbl, clk_s, rstn_s, !(cond), msg)

`endif

[src/pit_pkg.sv]
package pit_pkg;

  // Default coordinate width.
  localparam int COORD_WIDTH_DEF = 16;
  // Ray end x after reset.
  localparam int RAY_END_RESET   = 9999;
  // Depth of the queue between front and back.
  localparam int MID_DEPTH_DEF   = 4;
  // Depth of the result queue.
  localparam int OUT_DEPTH_DEF   = 2;
  // Vertex count at which a polygon is complete enough to test.
  localparam logic [1:0] SEEN_MAX = 2'd3;

  // Orientation class of three points.
  typedef enum logic [1:0] {
    ORI_ZERO,
    ORI_POS,
    ORI_NEG
  } ori_t;

  // Per-word control from front to back.
  typedef struct packed {
    logic ea_valid;  // edge prev -> vertex present
    logic eb_valid;  // closing edge vertex -> first present
    logic last;      // word closes the polygon
    logic few;       // polygon has fewer than three vertices
  } pit_ctl_t;

endpackage

[src/pit_fifo.sv]
`include "assert_macros.svh"

module pit_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] CNT_MAX = (AW+1)'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_MAX);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and count, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store incoming word.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_MAX, "fifo count beyond depth")

endmodule

[src/pit_front.sv]
`include "assert_macros.svh"

module pit_front #(
  parameter int CW = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  logic signed [CW-1:0] vertex_x,
  input  logic signed [CW-1:0] vertex_y,
  input  logic signed [CW-1:0] point_x,
  input  logic signed [CW-1:0] point_y,
  input  logic                last_vertex,
  // edge queue
  output logic                q_push,
  input  logic                q_full,
  output pit_pkg::pit_ctl_t   q_ctl,
  output logic signed [CW-1:0] q_prev_x,
  output logic signed [CW-1:0] q_prev_y,
  output logic signed [CW-1:0] q_vert_x,
  output logic signed [CW-1:0] q_vert_y,
  output logic signed [CW-1:0] q_first_x,
  output logic signed [CW-1:0] q_first_y,
  output logic signed [CW-1:0] q_pt_x,
  output logic signed [CW-1:0] q_pt_y
);

  logic signed [CW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r, qpx_r, qpy_r;
  logic [1:0]           seen_r, seen_nxt, seen_inc;
  logic                 acc, start;

  assign full   = q_full;
  assign acc    = push && !q_full;
  assign q_push = acc;
  assign start  = (seen_r == 2'd0);

  // Saturating vertex count for this word.
  assign seen_inc = (seen_r == pit_pkg::SEEN_MAX) ? seen_r : seen_r + 2'd1;
  assign seen_nxt = last_vertex ? 2'd0 : seen_inc;

  // Classify the word: edges it closes, polygon end and too few vertices.
  always_comb begin
    q_ctl.ea_valid = !start;
    q_ctl.eb_valid = last_vertex;
    q_ctl.last     = last_vertex;
    q_ctl.few      = (seen_inc < pit_pkg::SEEN_MAX);
  end

  assign q_prev_x  = prev_x_r;
  assign q_prev_y  = prev_y_r;
  assign q_vert_x  = vertex_x;
  assign q_vert_y  = vertex_y;
  assign q_first_x = start ? vertex_x : first_x_r;
  assign q_first_y = start ? vertex_y : first_y_r;
  assign q_pt_x    = start ? point_x : qpx_r;
  assign q_pt_y    = start ? point_y : qpy_r;

  // Track polygon progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (acc) begin
      seen_r <= seen_nxt;
    end
  end

  // Hold first vertex, previous vertex and query point.
  always_ff @(posedge clk) begin
    if (acc) begin
      prev_x_r <= vertex_x;
      prev_y_r <= vertex_y;
      if (start) begin
        first_x_r <= vertex_x;
        first_y_r <= vertex_y;
        qpx_r     <= point_x;
        qpy_r     <= point_y;
      end
    end
  end

  `ASSERT_CLK(a_seen_clear, clk, rst_n, (acc && last_vertex) |=> (seen_r == 2'd0), "polygon count not cleared after last vertex")

endmodule

[src/pit_orient.sv]
module pit_orient #(
  parameter int CW = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] a_x,
  input  logic signed [CW-1:0] a_y,
  input  logic signed [CW-1:0] b_x,
  input  logic signed [CW-1:0] b_y,
  input  logic signed [CW-1:0] c_x,
  input  logic signed [CW-1:0] c_y,
  output pit_pkg::ori_t        ori
);

  localparam int D = CW + 1;
  localparam int P = 2 * D;

  logic signed [D-1:0] dy_ab_r, dx_cb_r, dx_ab_r, dy_cb_r;
  logic signed [P-1:0] p_r, q_r;
  logic signed [P:0]   diff;
  pit_pkg::ori_t       ori_r;

  assign diff = P'(p_r) - P'(q_r);
  assign ori  = ori_r;

  // Three stages: differences, products, sign of (c-b)x(b-a).
  always_ff @(posedge clk) begin
    if (en) begin
      dy_ab_r <= D'(b_y) - D'(a_y);
      dx_cb_r <= D'(c_x) - D'(b_x);
      dx_ab_r <= D'(b_x) - D'(a_x);
      dy_cb_r <= D'(c_y) - D'(b_y);
      p_r     <= dy_ab_r * dx_cb_r;
      q_r     <= dx_ab_r * dy_cb_r;
      if (diff == '0) begin
        ori_r <= pit_pkg::ORI_ZERO;
      end else if (diff[P]) begin
        ori_r <= pit_pkg::ORI_NEG;
      end else begin
        ori_r <= pit_pkg::ORI_POS;
      end
    end
  end

endmodule

[src/pit_back.sv]
`include "assert_macros.svh"

module pit_back #(
  parameter int CW = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [CW-1:0] ray_end_x,
  // edge queue
  input  logic                 q_empty,
  output logic                 q_pop,
  input  pit_pkg::pit_ctl_t    q_ctl,
  input  logic signed [CW-1:0] q_prev_x,
  input  logic signed [CW-1:0] q_prev_y,
  input  logic signed [CW-1:0] q_vert_x,
  input  logic signed [CW-1:0] q_vert_y,
  input  logic signed [CW-1:0] q_first_x,
  input  logic signed [CW-1:0] q_first_y,
  input  logic signed [CW-1:0] q_pt_x,
  input  logic signed [CW-1:0] q_pt_y,
  // result queue
  output logic                 r_push,
  input  logic                 r_full,
  output logic                 r_inside,
  output logic                 r_collinear,
  output logic                 r_few
);

  typedef struct packed {
    pit_pkg::pit_ctl_t ctl;
    logic              box_a;
    logic              box_b;
  } stage_t;

  logic                 s1_valid_r, s2_valid_r, s3_valid_r;
  stage_t               s1_r, s2_r, s3_r, s0;
  logic                 adv;
  logic                 par_r, par_nxt, early_r, early_nxt, ans_r, ans_nxt;

  logic signed [CW-1:0] ea_x [2];
  logic signed [CW-1:0] ea_y [2];
  logic signed [CW-1:0] eb_x [2];
  logic signed [CW-1:0] eb_y [2];
  pit_pkg::ori_t        o_abp [2];
  pit_pkg::ori_t        o_abr [2];
  pit_pkg::ori_t        o_pra [2];
  pit_pkg::ori_t        o_prb [2];
  pit_pkg::ori_t        o_apb [2];
  logic [1:0]           hit, coll, ev, box;

  // Stall only when a result has no room.
  assign adv   = !(s3_valid_r && s3_r.ctl.last && r_full);
  assign q_pop = adv && !q_empty;

  // Edge A: previous -> vertex. Edge B: vertex -> first.
  assign ea_x[0] = q_prev_x;
  assign ea_y[0] = q_prev_y;
  assign eb_x[0] = q_vert_x;
  assign eb_y[0] = q_vert_y;
  assign ea_x[1] = q_vert_x;
  assign ea_y[1] = q_vert_y;
  assign eb_x[1] = q_first_x;
  assign eb_y[1] = q_first_y;

  // Bounding box of each edge against the point.
  always_comb begin
    s0.ctl   = q_ctl;
    s0.box_a = (q_pt_x <= q_prev_x || q_pt_x <= q_vert_x) &&
               (q_pt_x >= q_prev_x || q_pt_x >= q_vert_x) &&
               (q_pt_y <= q_prev_y || q_pt_y <= q_vert_y) &&
               (q_pt_y >= q_prev_y || q_pt_y >= q_vert_y);
    s0.box_b = (q_pt_x <= q_vert_x || q_pt_x <= q_first_x) &&
               (q_pt_x >= q_vert_x || q_pt_x >= q_first_x) &&
               (q_pt_y <= q_vert_y || q_pt_y <= q_first_y) &&
               (q_pt_y >= q_vert_y || q_pt_y >= q_first_y);
  end

  // Five orientation lanes per edge.
  for (genvar e = 0; e < 2; e++) begin : g_edge
    pit_orient #(.CW(CW)) u_abp (
      .clk(clk), .en(adv),
      .a_x(ea_x[e]), .a_y(ea_y[e]), .b_x(eb_x[e]), .b_y(eb_y[e]),
      .c_x(q_pt_x), .c_y(q_pt_y), .ori(o_abp[e])
    );
    pit_orient #(.CW(CW)) u_abr (
      .clk(clk), .en(adv),
      .a_x(ea_x[e]), .a_y(ea_y[e]), .b_x(eb_x[e]), .b_y(eb_y[e]),
      .c_x(ray_end_x), .c_y(q_pt_y), .ori(o_abr[e])
    );
    pit_orient #(.CW(CW)) u_pra (
      .clk(clk), .en(adv),
      .a_x(q_pt_x), .a_y(q_pt_y), .b_x(ray_end_x), .b_y(q_pt_y),
      .c_x(ea_x[e]), .c_y(ea_y[e]), .ori(o_pra[e])
    );
    pit_orient #(.CW(CW)) u_prb (
      .clk(clk), .en(adv),
      .a_x(q_pt_x), .a_y(q_pt_y), .b_x(ray_end_x), .b_y(q_pt_y),
      .c_x(eb_x[e]), .c_y(eb_y[e]), .ori(o_prb[e])
    );
    pit_orient #(.CW(CW)) u_apb (
      .clk(clk), .en(adv),
      .a_x(ea_x[e]), .a_y(ea_y[e]), .b_x(q_pt_x), .b_y(q_pt_y),
      .c_x(eb_x[e]), .c_y(eb_y[e]), .ori(o_apb[e])
    );
    assign hit[e]  = (o_abp[e] != o_abr[e]) && (o_pra[e] != o_prb[e]);
    assign coll[e] = (o_apb[e] == pit_pkg::ORI_ZERO);
  end

  assign ev[0]  = s3_r.ctl.ea_valid;
  assign ev[1]  = s3_r.ctl.eb_valid;
  assign box[0] = s3_r.box_a;
  assign box[1] = s3_r.box_b;

  // Apply edge A then edge B to the crossing state.
  always_comb begin
    par_nxt   = par_r;
    early_nxt = early_r;
    ans_nxt   = ans_r;
    for (int e = 0; e < 2; e++) begin
      if (ev[e] && !early_nxt && hit[e]) begin
        if (coll[e]) begin
          early_nxt = 1'b1;
          ans_nxt   = box[e];
        end else begin
          par_nxt = !par_nxt;
        end
      end
    end
  end

  // Form the result of a closing word.
  assign r_push      = adv && s3_valid_r && s3_r.ctl.last;
  assign r_few       = s3_r.ctl.few;
  assign r_collinear = !s3_r.ctl.few && early_nxt;
  assign r_inside    = !s3_r.ctl.few && (early_nxt ? ans_nxt : par_nxt);

  // Advance the control pipeline alongside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_pop;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s0;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  // Update polygon state; clear it once the result leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r   <= 1'b0;
      early_r <= 1'b0;
      ans_r   <= 1'b0;
    end else if (adv && s3_valid_r) begin
      if (s3_r.ctl.last) begin
        par_r   <= 1'b0;
        early_r <= 1'b0;
        ans_r   <= 1'b0;
      end else begin
        par_r   <= par_nxt;
        early_r <= early_nxt;
        ans_r   <= ans_nxt;
      end
    end
  end

  `ASSERT_CLK(a_state_clear, clk, rst_n, r_push |=> (!par_r && !early_r && !ans_r), "state kept")
  `ASSERT_CLK(a_stall_hold, clk, rst_n, (s3_valid_r && !adv) |=> s3_valid_r, "stalled word lost")

endmodule

[src/point_in_polygon_test_unit.sv]
// Point-in-polygon test by ray casting.
// Input channel: one polygon vertex per word on in_vertex_x/y; the query
// point rides on in_point_x/y and is taken from the first word of each
// polygon. in_last_vertex closes the polygon. A word is taken on a rising
// edge with push high and full low.
// Result channel: one word per closed polygon (inside, collinear decision,
// too few vertices), shown while empty is low and taken with pop.
// Configuration: cfg_ray_end_x is written when valid is high; ready is
// always high. Write it only while no polygon is in flight.
// Throughput: one vertex per cycle while the result queue has room; the
// back end has its own lanes for each edge a word closes and runs them in
// parallel, so no vertex waits on another. A closing vertex goes through
// the edge queue and three orientation stages into the result queue.
// Reset clears the queues, the polygon state and sets the ray end to 9999.
// When pop stays low the result queue fills, the back end holds, then the
// edge queue fills and full rises; no word is lost.
module point_in_polygon_test_unit #(
  parameter int COORD_W   = pit_pkg::COORD_WIDTH_DEF,
  parameter int MID_DEPTH = pit_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = pit_pkg::OUT_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] in_vertex_x,
  input  logic signed [COORD_W-1:0] in_vertex_y,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic                      in_last_vertex,
  // result channel
  output logic                      empty,
  input  logic                      pop,
  output logic                      out_inside_res,
  output logic                      out_decided_by_collinear,
  output logic                      out_too_few_vertices,
  // configuration
  input  logic                      valid,
  output logic                      ready,
  input  logic signed [COORD_W-1:0] cfg_ray_end_x
);

  localparam int MW = 8 * COORD_W + $bits(pit_pkg::pit_ctl_t);

  logic signed [COORD_W-1:0] ray_r;

  pit_pkg::pit_ctl_t         f_ctl, b_ctl;
  logic signed [COORD_W-1:0] f_prev_x, f_prev_y, f_vert_x, f_vert_y;
  logic signed [COORD_W-1:0] f_first_x, f_first_y, f_pt_x, f_pt_y;
  logic signed [COORD_W-1:0] b_prev_x, b_prev_y, b_vert_x, b_vert_y;
  logic signed [COORD_W-1:0] b_first_x, b_first_y, b_pt_x, b_pt_y;
  logic [MW-1:0]             mid_wdata, mid_rdata;
  logic                      mid_push, mid_full, mid_pop, mid_empty;
  logic                      r_push, r_full, r_inside, r_coll, r_few;
  logic [2:0]                r_rdata;

  // Hold the ray end register.
  assign ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= COORD_W'(pit_pkg::RAY_END_RESET);
    end else if (valid && ready) begin
      ray_r <= cfg_ray_end_x;
    end
  end

  pit_front #(.CW(COORD_W)) u_front (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .vertex_x(in_vertex_x), .vertex_y(in_vertex_y),
    .point_x(in_point_x), .point_y(in_point_y),
    .last_vertex(in_last_vertex),
    .q_push(mid_push), .q_full(mid_full), .q_ctl(f_ctl),
    .q_prev_x(f_prev_x), .q_prev_y(f_prev_y),
    .q_vert_x(f_vert_x), .q_vert_y(f_vert_y),
    .q_first_x(f_first_x), .q_first_y(f_first_y),
    .q_pt_x(f_pt_x), .q_pt_y(f_pt_y)
  );

  assign mid_wdata = {f_ctl, f_prev_x, f_prev_y, f_vert_x, f_vert_y,
                      f_first_x, f_first_y, f_pt_x, f_pt_y};

  pit_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(mid_push), .wdata(mid_wdata), .full(mid_full),
    .pop(mid_pop), .rdata(mid_rdata), .empty(mid_empty)
  );

  assign {b_ctl, b_prev_x, b_prev_y, b_vert_x, b_vert_y,
          b_first_x, b_first_y, b_pt_x, b_pt_y} = mid_rdata;

  pit_back #(.CW(COORD_W)) u_back (
    .clk(clk), .rst_n(rst_n), .ray_end_x(ray_r),
    .q_empty(mid_empty), .q_pop(mid_pop), .q_ctl(b_ctl),
    .q_prev_x(b_prev_x), .q_prev_y(b_prev_y),
    .q_vert_x(b_vert_x), .q_vert_y(b_vert_y),
    .q_first_x(b_first_x), .q_first_y(b_first_y),
    .q_pt_x(b_pt_x), .q_pt_y(b_pt_y),
    .r_push(r_push), .r_full(r_full),
    .r_inside(r_inside), .r_collinear(r_coll), .r_few(r_few)
  );

  pit_fifo #(.WIDTH(3), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(r_push), .wdata({r_inside, r_coll, r_few}), .full(r_full),
    .pop(pop), .rdata(r_rdata), .empty(empty)
  );

  assign out_inside_res           = r_rdata[2];
  assign out_decided_by_collinear = r_rdata[1];
  assign out_too_few_vertices     = r_rdata[0];

endmodule

[tb/pip_checker.sv]
`timescale 1ns / 100ps

// Watches the vertex, result and ray-end channels of the point-in-polygon unit,
// predicts each polygon verdict and compares it with what the unit returns.
module pip_checker #(
  parameter int CW = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic signed [CW-1:0] in_vertex_x,
  input  logic signed [CW-1:0] in_vertex_y,
  input  logic signed [CW-1:0] in_point_x,
  input  logic signed [CW-1:0] in_point_y,
  input  logic                 in_last_vertex,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 out_inside_res,
  input  logic                 out_decided_by_collinear,
  input  logic                 out_too_few_vertices,
  input  logic                 valid,
  input  logic                 ready,
  input  logic signed [CW-1:0] cfg_ray_end_x,
  output int                   fails,
  output int                   pending
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic in_poly;
    logic collinear;
    logic few;
  } verdict_t;

  // Verdicts predicted for closed polygons, oldest first
  verdict_t verdict_q[$];

  // Predicted polygon state and ray end
  logic signed [CW-1:0] ray_end;
  logic signed [CW-1:0] first_x, first_y, prev_x, prev_y, query_x, query_y;
  logic [1:0]           seen;
  logic                 parity, collinear_hit, collinear_inside;
  int                   mismatches;

  assign fails = mismatches;

  // Sign of (b.y-a.y)*(c.x-b.x) - (b.x-a.x)*(c.y-b.y), exact in 64 bits
  function automatic pit_pkg::ori_t orientation(input longint ax, ay, bx, by, cx, cy);
    longint det;
    det = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
    if (det == 0) return pit_pkg::ORI_ZERO;
    return (det < 0) ? pit_pkg::ORI_NEG : pit_pkg::ORI_POS;
  endfunction

  // Test one edge against the ray; count a crossing or settle on a collinear one
  task automatic cross_edge(input longint ax, ay, bx, by);
    longint px, py, rx;
    logic   in_x, in_y;
    px = query_x;
    py = query_y;
    rx = ray_end;
    if (collinear_hit) return;
    if (orientation(ax, ay, bx, by, px, py) != orientation(ax, ay, bx, by, rx, py) &&
        orientation(px, py, rx, py, ax, ay) != orientation(px, py, rx, py, bx, by)) begin
      if (orientation(ax, ay, px, py, bx, by) == pit_pkg::ORI_ZERO) begin
        in_x = (ax <= px && px <= bx) || (bx <= px && px <= ax);
        in_y = (ay <= py && py <= by) || (by <= py && py <= ay);
        collinear_hit    = 1'b1;
        collinear_inside = in_x && in_y;
      end else begin
        parity = ~parity;
      end
    end
  endtask

  // Advance the polygon by one vertex word; queue a verdict when it closes
  task automatic take_vertex();
    verdict_t v;
    if (seen == 2'd0) begin
      first_x          = in_vertex_x;
      first_y          = in_vertex_y;
      query_x          = in_point_x;
      query_y          = in_point_y;
      parity           = 1'b0;
      collinear_hit    = 1'b0;
      collinear_inside = 1'b0;
    end else begin
      cross_edge(prev_x, prev_y, in_vertex_x, in_vertex_y);
    end
    if (seen < pit_pkg::SEEN_MAX) seen = seen + 2'd1;
    prev_x = in_vertex_x;
    prev_y = in_vertex_y;
    if (!in_last_vertex) return;

    // Closing edge, last vertex back to the first
    cross_edge(in_vertex_x, in_vertex_y, first_x, first_y);
    if (seen < pit_pkg::SEEN_MAX) begin
      v = '{in_poly: 1'b0, collinear: 1'b0, few: 1'b1};
    end else if (collinear_hit) begin
      v = '{in_poly: collinear_inside, collinear: 1'b1, few: 1'b0};
    end else begin
      v = '{in_poly: parity, collinear: 1'b0, few: 1'b0};
    end
    verdict_q.push_back(v);
    seen             = 2'd0;
    parity           = 1'b0;
    collinear_hit    = 1'b0;
    collinear_inside = 1'b0;
  endtask

  always @(posedge clk) begin
    verdict_t want, got;
    if (!rst_n) begin
      ray_end          = CW'(pit_pkg::RAY_END_RESET);
      first_x          = '0;
      first_y          = '0;
      prev_x           = '0;
      prev_y           = '0;
      query_x          = '0;
      query_y          = '0;
      seen             = 2'd0;
      parity           = 1'b0;
      collinear_hit    = 1'b0;
      collinear_inside = 1'b0;
      mismatches       = 0;
      verdict_q.delete();
      pending <= 0;
    end else begin
      if (valid && ready) ray_end = cfg_ray_end_x;
      if (push && !full) take_vertex();

      // Compare the popped word with the oldest prediction
      if (pop && !empty) begin
        got = '{in_poly: out_inside_res, collinear: out_decided_by_collinear,
                few: out_too_few_vertices};
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result word in=%0b col=%0b few=%0b",
                     $realtime, got.in_poly, got.collinear, got.few);
        end else begin
          want = verdict_q.pop_front();
          if (got.in_poly !== want.in_poly || got.collinear !== want.collinear ||
              got.few !== want.few) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: mismatch exp in=%0b col=%0b few=%0b got in=%0b col=%0b few=%0b",
                       $realtime, want.in_poly, want.collinear, want.few,
                       got.in_poly, got.collinear, got.few);
          end
        end
      end
      pending <= verdict_q.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int CW            = pit_pkg::COORD_WIDTH_DEF;
  localparam int SEGMENT_WORDS = 225;
  localparam int DRAIN_CYCLES  = 12;
  localparam int STALL_LIMIT   = 3000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic signed [CW-1:0] in_vertex_x = '0;
  logic signed [CW-1:0] in_vertex_y = '0;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic                 in_last_vertex = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 out_inside_res, out_decided_by_collinear, out_too_few_vertices;
  logic                 cfg_valid = 1'b0;
  logic                 ready;
  logic signed [CW-1:0] cfg_ray_end_x = '0;
  int                   fails, pending;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_in_polygon_test_unit dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .push                     (push),
    .full                     (full),
    .in_vertex_x              (in_vertex_x),
    .in_vertex_y              (in_vertex_y),
    .in_point_x               (in_point_x),
    .in_point_y               (in_point_y),
    .in_last_vertex           (in_last_vertex),
    .empty                    (empty),
    .pop                      (pop),
    .out_inside_res           (out_inside_res),
    .out_decided_by_collinear (out_decided_by_collinear),
    .out_too_few_vertices     (out_too_few_vertices),
    .valid                    (cfg_valid),
    .ready                    (ready),
    .cfg_ray_end_x            (cfg_ray_end_x)
  );

  pip_checker #(.CW(CW)) u_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .push                     (push),
    .full                     (full),
    .in_vertex_x              (in_vertex_x),
    .in_vertex_y              (in_vertex_y),
    .in_point_x               (in_point_x),
    .in_point_y               (in_point_y),
    .in_last_vertex           (in_last_vertex),
    .empty                    (empty),
    .pop                      (pop),
    .out_inside_res           (out_inside_res),
    .out_decided_by_collinear (out_decided_by_collinear),
    .out_too_few_vertices     (out_too_few_vertices),
    .valid                    (cfg_valid),
    .ready                    (ready),
    .cfg_ray_end_x            (cfg_ray_end_x),
    .fails                    (fails),
    .pending                  (pending)
  );

  // Stall the result side at the current rate
  always @(posedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // End the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one vertex word after a random gap and hold it until taken
  task automatic send_vertex(input int vx, vy, px, py, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_vertex_x    <= vx[CW-1:0];
    in_vertex_y    <= vy[CW-1:0];
    in_point_x     <= px[CW-1:0];
    in_point_y     <= py[CW-1:0];
    in_last_vertex <= last;
    do @(posedge clk); while (full);
  endtask

  // Mostly tight clusters so vertices land on the ray and on the point
  function automatic int rand_coord(input int mode);
    if (mode < 6) return $urandom_range(12) - 6;
    if (mode < 9) return $urandom_range(4000) - 2000;
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      default: return $urandom_range(65535) - 32768;
    endcase
  endfunction

  // Send one random polygon; the point sometimes sits on a vertex
  task automatic random_polygon(output int n);
    int xs[8], ys[8];
    int mode, px, py, k;
    n    = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
    mode = $urandom_range(9);
    for (k = 0; k < n; k++) begin
      xs[k] = rand_coord(mode);
      ys[k] = rand_coord(mode);
    end
    px = rand_coord(mode);
    py = rand_coord(mode);
    if ($urandom_range(9) == 0) begin
      k  = $urandom_range(n - 1);
      px = xs[k];
      py = ys[k];
    end
    for (k = 0; k < n; k++) begin
      if (k == 0) send_vertex(xs[k], ys[k], px, py, n == 1);
      else        send_vertex(xs[k], ys[k], $urandom, $urandom, k == n - 1);
    end
  endtask

  // Let every verdict come back and the pipeline settle before a ray-end write
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ray_end(input int value);
    cfg_valid     <= 1'b1;
    cfg_ray_end_x <= value[CW-1:0];
    do @(posedge clk); while (!ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int seg, words, n;
    int ray_ends[8];
    ray_ends = '{pit_pkg::RAY_END_RESET, 32767, -32768, 0, $urandom_range(65535) - 32768, -1,
                 $urandom_range(16) - 8, pit_pkg::RAY_END_RESET};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polygons under the reset ray end
    send_vertex(0, 0, 0, 0, 1'b1);
    send_vertex(32767, 32767, -32768, -32768, 1'b0);
    send_vertex(-32768, -32768, 0, 0, 1'b1);
    send_vertex(-10, -10, 0, 0, 1'b0);
    send_vertex(10, -10, 0, 0, 1'b0);
    send_vertex(0, 10, 0, 0, 1'b1);
    send_vertex(-10, -10, 20, 0, 1'b0);
    send_vertex(10, -10, 0, 0, 1'b0);
    send_vertex(0, 10, 0, 0, 1'b1);
    // point on a slanted edge
    send_vertex(0, -10, 5, 0, 1'b0);
    send_vertex(10, 10, 0, 0, 1'b0);
    send_vertex(-10, 10, 0, 0, 1'b1);
    // point on a vertex
    send_vertex(-5, -5, 5, -5, 1'b0);
    send_vertex(5, -5, 0, 0, 1'b0);
    send_vertex(0, 5, 0, 0, 1'b1);
    // full-range square
    send_vertex(-32768, -32768, 0, 0, 1'b0);
    send_vertex(32767, -32768, -1, -1, 1'b0);
    send_vertex(32767, 32767, 0, 0, 1'b0);
    send_vertex(-32768, 32767, 0, 0, 1'b1);

    // Random polygons over several ray ends and idling patterns
    for (seg = 0; seg < 8; seg++) begin
      drain();
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      if (seg > 0) write_ray_end(ray_ends[seg]);
      words = 0;
      while (words < SEGMENT_WORDS) begin
        random_polygon(n);
        words += n;
      end
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
